@@ rtl/core/bbd_pkg.sv @@
package bbd_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned PIXEL_BITS_DEF = 12;

  // Configuration register layout
  localparam int unsigned WIDTH_REG_BITS  = 13;
  localparam int unsigned HEIGHT_REG_BITS = 16;
  localparam int unsigned CFG_DATA_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS    = 1;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(640);
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(480);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0),
    CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1)
  } cfg_reg_e;

  // Per-word control handed from the input stage to the kernel stage
  typedef struct packed {
    logic emit;      // word produces a result
    logic last;      // result is the last pixel of the frame
    logic top_ok;    // window row above the center lies inside the frame
    logic bot_ok;    // window row below the center lies inside the frame
    logic left_ok;   // window column left of the center lies inside the frame
    logic right_ok;  // window column right of the center lies inside the frame
    logic row_par;   // parity of the center row
    logic col_par;   // parity of the center column
  } ctl_t;

endpackage

@@ rtl/core/bbd_line_store.sv @@
module bbd_line_store import bbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH),
  localparam int unsigned DW = 2 * PIXEL_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  // Each entry holds {two rows up, one row up} for one column
  logic [DW-1:0] mem [MAX_WIDTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Same-address write in the read cycle: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

@@ rtl/core/bbd_kernel.sv @@
module bbd_kernel import bbd_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned QW = PIXEL_BITS + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  fire_i,
  input  ctl_t                  ctl_i,
  input  logic [PIXEL_BITS-1:0] pix_i,
  input  logic [PIXEL_BITS-1:0] up_i,
  input  logic [PIXEL_BITS-1:0] lo_i,
  output logic                  valid_o,
  output logic [QW-1:0]         red_o,
  output logic [QW-1:0]         green_o,
  output logic [QW-1:0]         blue_o,
  output logic                  last_o
);

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  function automatic chan_e chan_of(input logic py, input logic px);
    chan_e ch;
    if (!py && !px) begin
      ch = CH_RED;
    end else if (py && px) begin
      ch = CH_BLUE;
    end else begin
      ch = CH_GREEN;
    end
    return ch;
  endfunction

  // Window keeps the two most recent columns; the third is the incoming one
  logic [PIXEL_BITS-1:0] win_q   [3][2];
  logic [PIXEL_BITS-1:0] col_new [3];
  logic [PIXEL_BITS-1:0] tap     [3][3];
  logic [2:0]            row_ok;
  logic [2:0]            col_ok;
  logic [QW-1:0]         s_corner, s_vert, s_horz, s_ctr;
  logic [QW-1:0]         grp_rb [4];
  logic [QW-1:0]         grp_g  [4];
  chan_e                 grp_ch [4];
  logic [QW-1:0]         red_d, green_d, blue_d;
  logic                  b_valid_q;
  logic [QW-1:0]         b_red_q, b_green_q, b_blue_q;
  logic                  b_last_q;

  assign col_new[0] = up_i;
  assign col_new[1] = lo_i;
  assign col_new[2] = pix_i;

  assign row_ok = {ctl_i.bot_ok, 1'b1, ctl_i.top_ok};
  assign col_ok = {ctl_i.right_ok, 1'b1, ctl_i.left_ok};

  // Out-of-frame samples read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tap[i][0] = (row_ok[i] && col_ok[0]) ? win_q[i][0] : '0;
      tap[i][1] = (row_ok[i] && col_ok[1]) ? win_q[i][1] : '0;
      tap[i][2] = (row_ok[i] && col_ok[2]) ? col_new[i] : '0;
    end
  end

  // Corners, vertical pair, horizontal pair and center each share one color
  always_comb begin
    s_corner = QW'(tap[0][0]) + QW'(tap[0][2]) + QW'(tap[2][0]) + QW'(tap[2][2]);
    s_vert   = QW'(tap[0][1]) + QW'(tap[2][1]);
    s_horz   = QW'(tap[1][0]) + QW'(tap[1][2]);
    s_ctr    = {tap[1][1], 2'b00};

    grp_rb[0] = s_corner;
    grp_g[0]  = '0;
    grp_ch[0] = chan_of(!ctl_i.row_par, !ctl_i.col_par);
    grp_rb[1] = {s_vert[QW-2:0], 1'b0};
    grp_g[1]  = s_vert;
    grp_ch[1] = chan_of(!ctl_i.row_par, ctl_i.col_par);
    grp_rb[2] = {s_horz[QW-2:0], 1'b0};
    grp_g[2]  = s_horz;
    grp_ch[2] = chan_of(ctl_i.row_par, !ctl_i.col_par);
    grp_rb[3] = s_ctr;
    grp_g[3]  = s_ctr;
    grp_ch[3] = chan_of(ctl_i.row_par, ctl_i.col_par);
  end

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    for (int k = 0; k < 4; k++) begin
      case (grp_ch[k])
        CH_RED:   red_d   = red_d + grp_rb[k];
        CH_BLUE:  blue_d  = blue_d + grp_rb[k];
        CH_GREEN: green_d = green_d + grp_g[k];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= col_new[i];
      end
    end
    if (adv_i && fire_i) begin
      b_red_q   <= red_d;
      b_green_q <= green_d;
      b_blue_q  <= blue_d;
      b_last_q  <= ctl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= fire_i && ctl_i.emit;
    end
  end

  assign valid_o = b_valid_q;
  assign red_o   = b_red_q;
  assign green_o = b_green_q;
  assign blue_o  = b_blue_q;
  assign last_o  = b_last_q;

endmodule

@@ rtl/core/bbd_luma.sv @@
module bbd_luma import bbd_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned QW = PIXEL_BITS + 2,
  localparam int unsigned SW = PIXEL_BITS + 4,
  localparam int unsigned K  = SW + 1,
  localparam int unsigned MW = SW + K
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [QW-1:0] red_i,
  input  logic [QW-1:0] green_i,
  input  logic [QW-1:0] blue_i,
  input  logic          last_i,
  input  logic          out_stall_i,
  output logic          ready_o,
  output logic          out_valid_o,
  output logic [QW-1:0] red_quarters_o,
  output logic [QW-1:0] green_quarters_o,
  output logic [QW-1:0] blue_quarters_o,
  output logic [QW-1:0] luma_quarters_o,
  output logic          frame_end_o
);

  // floor(x/3) == (x * ceil(2^K/3)) >> K for x < 2^SW
  localparam logic [K-1:0] RECIP = K'(((1 << K) + 2) / 3);

  logic [SW-1:0] sum;
  logic [MW-1:0] prod;
  logic [QW-1:0] luma_d;
  logic          out_valid_q;
  logic [QW-1:0] red_q, green_q, blue_q, luma_q;
  logic          last_q;

  assign sum    = SW'(red_i) + SW'(green_i) + SW'(blue_i) + SW'(1);
  assign prod   = MW'(sum) * MW'(RECIP);
  assign luma_d = prod[K +: QW];

  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      luma_q  <= luma_d;
      last_q  <= last_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign red_quarters_o   = red_q;
  assign green_quarters_o = green_q;
  assign blue_quarters_o  = blue_q;
  assign luma_quarters_o  = luma_q;
  assign frame_end_o      = last_q;

  // Rounded mean never leaves the span of the three channels
  a_luma_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      ((luma_q <= red_q) || (luma_q <= green_q) || (luma_q <= blue_q)) &&
      ((luma_q >= red_q) || (luma_q >= green_q) || (luma_q >= blue_q)))
    else $error("luma outside channel span");

endmodule

@@ rtl/core/bayer_bilinear_demosaic_luma.sv @@
// Bilinear Bayer demosaic with luminance. Raw samples come in raster order (red at
// even row/even column, blue at odd/odd, green elsewhere) and each pixel leaves as
// red, green and blue in quarter units (exact kernel sums, 1-2-4 for red/blue and the
// plus-shaped 1-4 kernel for green, out-of-frame samples taken as zero) plus luma,
// the mean of the three rounded to the nearest quarter. The result for the pixel at
// stream position k is released by the accepted word at position k+frame_width+1, so
// after the last pixel the source sends blanking words (req_type 1) until frame_end
// shows up; pixels sent during that flush are treated as blanking and dropped, and
// blanking words inside a frame are accepted and ignored. One word is accepted every
// clock while in_stall_o is low; three register stages (input, kernel sums, result)
// lie between acceptance of the releasing word and its result. The rate is set by
// the single read and single write per cycle of the line store, which holds the two
// previous rows packed per column. The line store is not cleared after reset: rows
// above the first and columns outside the frame are masked, so old contents never
// reach a result. frame_width and frame_height are to be written only while the
// block is idle, not enforced by the block; a write restarts the frame position.
module bayer_bilinear_demosaic_luma import bbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned QW = PIXEL_BITS + 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  // raw sample words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [PIXEL_BITS-1:0]    pixel_value_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [QW-1:0]            red_quarters_o,
  output logic [QW-1:0]            green_quarters_o,
  output logic [QW-1:0]            blue_quarters_o,
  output logic [QW-1:0]            luma_quarters_o,
  output logic                     frame_end_o
);

  localparam int unsigned WB    = $clog2(MAX_WIDTH + 1);  // holds the width itself
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);      // column index
  localparam int unsigned WC    = (WB > WIDTH_REG_BITS) ? WB : WIDTH_REG_BITS;
  localparam int unsigned RW    = HEIGHT_REG_BITS + 1;    // row incl. two flush rows

  // Configuration and stream position
  logic [WIDTH_REG_BITS-1:0]  width_q;
  logic [HEIGHT_REG_BITS-1:0] height_q;
  logic [COL_W-1:0]           col_q, col_d;
  logic [HEIGHT_REG_BITS-1:0] row_q, row_d;
  logic [WB-1:0]              flush_q, flush_d;

  // Effective geometry
  logic [WC-1:0]              w_ext;
  logic [WB-1:0]              w_eff;
  logic [HEIGHT_REG_BITS-1:0] h_eff;
  logic [WB-1:0]              col_nx;

  // Input-side decode
  logic                       flushing;   // all frame rows are in; draining
  logic                       tail;       // final flush word, releases the last pixel
  logic                       ignore;     // blanking inside a frame
  logic                       load;       // word enters the input stage
  logic [RW-1:0]              r_full;
  logic [COL_W-1:0]           col_idx;
  logic                       c0;
  logic                       ge1, ge2, ge3;
  logic [PIXEL_BITS-1:0]      v_d;
  ctl_t                       ctl_d;

  // Input stage
  logic                       a_valid_q;
  ctl_t                       a_ctl_q;
  logic [PIXEL_BITS-1:0]      a_pix_q;
  logic [COL_W-1:0]           a_col_q;

  // Handshake chain
  logic                       out_ready;
  logic                       b_valid;
  logic                       b_ready;
  logic                       a_ready;
  logic                       a_fire;

  // Line store and kernel wires
  logic [2*PIXEL_BITS-1:0]    st_rd;
  logic [PIXEL_BITS-1:0]      st_up, st_lo;
  logic [QW-1:0]              b_red, b_green, b_blue;
  logic                       b_last;

  // ---------------------------------------------------------------------------
  // Geometry: width 0 acts as 1, above MAX_WIDTH clamps; height 0 acts as 1
  // ---------------------------------------------------------------------------
  always_comb begin
    w_ext = WC'(width_q);
    if (width_q == '0) begin
      w_eff = WB'(1);
    end else if (w_ext > WC'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_q);
    end
    h_eff = (height_q == '0) ? HEIGHT_REG_BITS'(1) : height_q;
  end

  // ---------------------------------------------------------------------------
  // Position of the incoming word. In flush, row h is walked column by column
  // with zero samples, then one word at row h+1 releases the last pixel.
  // A word at column 0 finishes the previous row: its center is the last
  // column two rows up. Any other column c centers on (row-1, c-1).
  // ---------------------------------------------------------------------------
  always_comb begin
    flushing = (row_q >= h_eff);
    tail     = flushing && (flush_q >= w_eff);
    ignore   = !flushing && req_type_i;

    r_full   = flushing ? (RW'(h_eff) + RW'(tail)) : RW'(row_q);
    if (!flushing) begin
      col_idx = col_q;
    end else if (tail) begin
      col_idx = '0;
    end else begin
      col_idx = flush_q[COL_W-1:0];
    end
    c0  = (col_idx == '0);
    ge1 = (r_full != '0);
    ge2 = (r_full >= RW'(2));
    ge3 = (r_full >= RW'(3));

    v_d = flushing ? '0 : pixel_value_i;

    ctl_d.emit     = c0 ? ge2 : ge1;
    ctl_d.last     = tail;
    ctl_d.top_ok   = c0 ? ge3 : ge2;
    ctl_d.bot_ok   = c0 ? !tail : !flushing;
    ctl_d.left_ok  = c0 ? (w_eff >= WB'(2)) : (col_idx >= COL_W'(2));
    ctl_d.right_ok = !c0;
    ctl_d.row_par  = c0 ? r_full[0] : !r_full[0];
    ctl_d.col_par  = c0 ? !w_eff[0] : !col_idx[0];
  end

  // Next stream position
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    col_nx  = WB'(col_q) + WB'(1);
    if (!flushing) begin
      if (col_nx >= w_eff) begin
        col_d = '0;
        row_d = row_q + HEIGHT_REG_BITS'(1);
      end else begin
        col_d = col_nx[COL_W-1:0];
      end
    end else begin
      flush_d = flush_q + WB'(1);
    end
    if (tail) begin
      col_d   = '0;
      row_d   = '0;
      flush_d = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when the one after it has room
  // ---------------------------------------------------------------------------
  assign b_ready    = !b_valid || out_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign a_fire     = a_valid_q && b_ready;
  assign load       = in_valid_i && a_ready && !ignore;
  assign in_stall_o = !a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      col_q     <= '0;
      row_q     <= '0;
      flush_q   <= '0;
      a_valid_q <= 1'b0;
      a_ctl_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_REG_BITS-1:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_REG_BITS-1:0];
          default:          ;
        endcase
        col_q   <= '0;
        row_q   <= '0;
        flush_q <= '0;
      end else if (load) begin
        col_q   <= col_d;
        row_q   <= row_d;
        flush_q <= flush_d;
      end
      if (a_ready) begin
        a_valid_q <= load;
        a_ctl_q   <= ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      a_pix_q <= v_d;
      a_col_q <= col_idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: read at acceptance, rotated and written back when the word
  // leaves the input stage (upper <= lower, lower <= new sample)
  // ---------------------------------------------------------------------------
  bbd_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (load),
    .rd_addr_i (col_idx),
    .wr_en_i   (a_fire),
    .wr_addr_i (a_col_q),
    .wr_data_i ({st_lo, a_pix_q}),
    .rd_data_o (st_rd)
  );

  assign st_up = st_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign st_lo = st_rd[PIXEL_BITS-1:0];

  // 3x3 window and kernel sums
  bbd_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (b_ready),
    .fire_i  (a_fire),
    .ctl_i   (a_ctl_q),
    .pix_i   (a_pix_q),
    .up_i    (st_up),
    .lo_i    (st_lo),
    .valid_o (b_valid),
    .red_o   (b_red),
    .green_o (b_green),
    .blue_o  (b_blue),
    .last_o  (b_last)
  );

  // Luma and result register
  bbd_luma #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_luma (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (b_valid),
    .red_i            (b_red),
    .green_i          (b_green),
    .blue_i           (b_blue),
    .last_i           (b_last),
    .out_stall_i      (out_stall_i),
    .ready_o          (out_ready),
    .out_valid_o      (out_valid_o),
    .red_quarters_o   (red_quarters_o),
    .green_quarters_o (green_quarters_o),
    .blue_quarters_o  (blue_quarters_o),
    .luma_quarters_o  (luma_quarters_o),
    .frame_end_o      (frame_end_o)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && ctl_d.last && !cfg_we_i |=>
      (col_q == '0) && (row_q == '0) && (flush_q == '0))
    else $error("position not cleared after frame end");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WB'(col_q) < w_eff)
    else $error("column counter past row width");

  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q <= w_eff)
    else $error("flush counter past row width");

endmodule

@@ bench/bayer_bilinear_demosaic_luma_test.sv @@
module bayer_bilinear_demosaic_luma_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bbd_pkg::*;

  localparam int MAXW   = MAX_WIDTH_DEF;
  localparam int PB     = PIXEL_BITS_DEF;
  localparam int QW     = PB + 2;
  // cycles to let the pipe empty after the last expected word; the block has 3 stages
  localparam int SETTLE = 6;

  typedef enum logic {
    WORD_PIXEL = 1'b0,
    WORD_BLANK = 1'b1
  } word_kind_e;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_BLANK,
    ROW_SET_WIDTH,
    ROW_SET_HEIGHT
  } plan_op_e;

  typedef struct packed {
    logic [QW-1:0] red;
    logic [QW-1:0] green;
    logic [QW-1:0] blue;
    logic [QW-1:0] luma;
    logic          frame_end;
  } pix_rgb_t;

  // One directed step: a word or a register write. When pinned, the result word
  // released by this step is typed in here instead of taken from the predictor.
  typedef struct packed {
    plan_op_e                 op;
    logic [CFG_DATA_BITS-1:0] arg;
    logic                     pinned;
    pix_rgb_t                 want;
  } plan_row_t;

  // 1x1 frames: the lone pixel is red, only the center tap survives the masking,
  // so red = 4v and luma = (4v+1)/3. Each takes one pixel plus two flush words.
  localparam plan_row_t PLAN [26] = '{
    '{ROW_SET_WIDTH,  16'd1,    1'b0, '0},
    '{ROW_SET_HEIGHT, 16'd1,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0},  // blank inside a frame: dropped
    '{ROW_PIXEL,      16'd4095, 1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b1, '{14'd16380, 14'd0, 14'd0, 14'd5460, 1'b1}},
    '{ROW_PIXEL,      16'd0,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0},
    '{ROW_PIXEL,      16'd1234, 1'b1, '{14'd0, 14'd0, 14'd0, 14'd0, 1'b1}},  // pixel in flush
    '{ROW_PIXEL,      16'd1,    1'b0, '0},
    '{ROW_PIXEL,      16'd2048, 1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b1, '{14'd4, 14'd0, 14'd0, 14'd1, 1'b1}},
    // zero width and height both act as one
    '{ROW_SET_WIDTH,  16'd0,    1'b0, '0},
    '{ROW_SET_HEIGHT, 16'd0,    1'b0, '0},
    '{ROW_PIXEL,      16'd2,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b1, '{14'd8, 14'd0, 14'd0, 14'd3, 1'b1}},
    // 2x2 saturated frame, checked by the predictor
    '{ROW_SET_WIDTH,  16'd2,    1'b0, '0},
    '{ROW_SET_HEIGHT, 16'd2,    1'b0, '0},
    '{ROW_PIXEL,      16'd4095, 1'b0, '0},
    '{ROW_PIXEL,      16'd4095, 1'b0, '0},
    '{ROW_PIXEL,      16'd4095, 1'b0, '0},
    '{ROW_PIXEL,      16'd4095, 1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0},
    '{ROW_BLANK,      16'd0,    1'b0, '0}
  };

  // ---------------------------------------------------------------- signals
  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_reg_e                 cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     src_valid;
  logic                     src_stall;
  word_kind_e               word_type;
  logic [PB-1:0]            word_pixel;
  logic                     res_valid;
  logic                     res_stall;
  logic [QW-1:0]            res_red;
  logic [QW-1:0]            res_green;
  logic [QW-1:0]            res_blue;
  logic [QW-1:0]            res_luma;
  logic                     res_frame_end;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bayer_bilinear_demosaic_luma dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_data),
    .in_valid_i       (src_valid),
    .in_stall_o       (src_stall),
    .req_type_i       (word_type),
    .pixel_value_i    (word_pixel),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .red_quarters_o   (res_red),
    .green_quarters_o (res_green),
    .blue_quarters_o  (res_blue),
    .luma_quarters_o  (res_luma),
    .frame_end_o      (res_frame_end)
  );

  // ------------------------------------------------------- predictor state
  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  logic [PB-1:0]              two_up [MAXW];  // sample two rows above, per column
  logic [PB-1:0]              one_up [MAXW];  // sample one row above, per column
  logic [8:0][PB-1:0]         win;            // 3x3 window, row-major, newest column at 2
  int                         col_pos;
  int                         row_pos;
  int                         flush_pos;

  pix_rgb_t pending_pixels [$];  // expected result words, oldest first
  int       mismatches = 0;
  int       fed_words  = 0;      // words that moved the stream (ignored blanks excluded)
  int       src_mode   = 1;      // 0 no gaps, 1 random gap before each word, 2 rare gaps
  int       sink_mode  = 1;
  int       sink_hold  = 0;      // one-off long stall for the result side
  bit       pos_lost   = 1'b0;   // frame position unknown to the stimulus, rewrite a reg

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic void clear_demosaic_state();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    for (int i = 0; i < MAXW; i++) begin
      two_up[i] = '0;
      one_up[i] = '0;
    end
    win       = '0;
    col_pos   = 0;
    row_pos   = 0;
    flush_pos = 0;
  endfunction

  // Bilinear kernels over window m centered at (rc, cc); taps outside the frame drop.
  function automatic pix_rgb_t bilinear_rgb(input logic [8:0][PB-1:0] m,
                                            input int rc, input int cc,
                                            input int w, input int h);
    int unsigned sr, sg, sb, wrb, wg;
    int          y, x;
    pix_rgb_t    res;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int i = 0; i < 3; i++) begin
      y = rc - 1 + i;
      if (y < 0 || y >= h) continue;
      for (int j = 0; j < 3; j++) begin
        x = cc - 1 + j;
        if (x < 0 || x >= w) continue;
        wrb = (i == 1 ? 2 : 1) * (j == 1 ? 2 : 1);
        wg  = (i == 1 && j == 1) ? 4 : (((i == 1) != (j == 1)) ? 1 : 0);
        if (y % 2 == 0 && x % 2 == 0) sr += wrb * m[i*3+j];
        else if (y % 2 == 1 && x % 2 == 1) sb += wrb * m[i*3+j];
        else sg += wg * m[i*3+j];
      end
    end
    res.red       = QW'(sr);
    res.green     = QW'(sg);
    res.blue      = QW'(sb);
    res.luma      = QW'((sr + sg + sb + 1) / 3);
    res.frame_end = 1'b0;
    return res;
  endfunction

  // Advance the stream by one accepted word; returns 1 when a result word is due.
  function automatic bit demosaic_predict(input word_kind_e kind, input logic [PB-1:0] sample,
                                          output pix_rgb_t res, output bit ignored);
    int                 w, h, r, c, rc, cc;
    bit                 flushing, emit;
    logic [PB-1:0]      v, a, b;
    logic [8:0][PB-1:0] m;
    w        = active_width();
    h        = active_height();
    flushing = row_pos >= h;
    emit     = 1'b0;
    rc       = 0;
    cc       = 0;
    m        = '0;
    res      = '0;
    ignored  = 1'b0;
    if (!flushing && kind == WORD_BLANK) begin
      ignored = 1'b1;
      return 1'b0;
    end
    if (!flushing) begin
      r = row_pos;
      c = col_pos;
      v = sample;
    end else if (flush_pos < w) begin
      r = h;
      c = flush_pos;
      v = '0;
    end else begin
      r = h + 1;
      c = 0;
      v = '0;
    end
    if (c >= w) c = 0;

    a         = two_up[c];
    b         = one_up[c];
    two_up[c] = b;
    one_up[c] = v;

    // column 0 closes the previous row: its last pixel is centered, right side empty
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        m[i*3]   = win[i*3+1];
        m[i*3+1] = win[i*3+2];
        m[i*3+2] = '0;
      end
      if (r >= 2) begin
        emit = 1'b1;
        rc   = r - 2;
        cc   = w - 1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = a;
    win[5] = b;
    win[8] = v;
    if (c != 0) begin
      m = win;
      if (r >= 1) begin
        emit = 1'b1;
        rc   = r - 1;
        cc   = c - 1;
      end
    end

    if (!flushing) begin
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
    end else begin
      flush_pos = (flush_pos + 1) & 13'h1fff;
    end

    if (!emit) return 1'b0;
    res           = bilinear_rgb(m, rc, cc, w, h);
    res.frame_end = (rc == h - 1) && (cc == w - 1);
    if (res.frame_end) begin
      col_pos   = 0;
      row_pos   = 0;
      flush_pos = 0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_reg_write(input cfg_reg_e idx,
                                            input logic [CFG_DATA_BITS-1:0] data);
    if (idx == CFG_FRAME_WIDTH) width_reg = data[WIDTH_REG_BITS-1:0];
    else height_reg = data[HEIGHT_REG_BITS-1:0];
    col_pos   = 0;
    row_pos   = 0;
    flush_pos = 0;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic int idle_draw(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(14, 0);
      default: return ($urandom_range(7, 0) == 0) ? $urandom_range(14, 0) : 0;
    endcase
  endfunction

  function automatic logic [PB-1:0] pick_sample();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return PB'($urandom_range((1 << PB) - 1, 0));
    endcase
  endfunction

  // Offer one word and hold it until taken, then run the predictor on it.
  task automatic send_word(input word_kind_e kind, input logic [PB-1:0] sample,
                           input bit pinned = 1'b0, input pix_rgb_t want = '0);
    int       gap;
    bit       ignored;
    pix_rgb_t got;
    gap = idle_draw(src_mode);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid  <= 1'b1;
    word_type  <= kind;
    word_pixel <= sample;
    do @(posedge clk); while (src_stall);
    if (demosaic_predict(kind, sample, got, ignored) && !pinned) pending_pixels.push_back(got);
    if (pinned) pending_pixels.push_back(want);
    if (!ignored) fed_words++;
  endtask

  // Stop offering until every expected word is back.
  task automatic drain();
    src_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Register writes only with the block idle; blanks can still be in flight, so settle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] data);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_reg_write(idx, data);
    pos_lost = 1'b0;
  endtask

  task automatic run_row(input plan_row_t row);
    case (row.op)
      ROW_SET_WIDTH:  write_reg(CFG_FRAME_WIDTH, row.arg);
      ROW_SET_HEIGHT: write_reg(CFG_FRAME_HEIGHT, row.arg);
      default: send_word(row.op == ROW_BLANK ? WORD_BLANK : WORD_PIXEL, row.arg[PB-1:0],
                         row.pinned, row.want);
    endcase
  endtask

  // One frame of random samples with stray blanks, then the flush, where some
  // words are pixels that the block must treat as blanks. cut > 0 stops early.
  task automatic send_frame(input int cut, input int pause_at);
    int w, total;
    w     = active_width();
    total = w * active_height();
    for (int i = 0; i < ((cut > 0) ? cut : total); i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(15, 0) == 0) send_word(WORD_BLANK, pick_sample());
      send_word(WORD_PIXEL, pick_sample());
    end
    if (cut > 0) begin
      pos_lost = 1'b1;
    end else begin
      repeat (w + 1) send_word(($urandom_range(3, 0) == 0) ? WORD_PIXEL : WORD_BLANK,
                               pick_sample());
    end
  endtask

  task automatic random_phase();
    int pick, total, cut, pause_at;
    src_mode  = $urandom_range(2, 0);
    sink_mode = $urandom_range(2, 0);
    pick      = pos_lost ? $urandom_range(3, 1) : $urandom_range(3, 0);
    if (pick[0]) begin
      case ($urandom_range(15, 0))
        0:       write_reg(CFG_FRAME_WIDTH, '0);
        1, 2:    write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'($urandom_range(40, 9)));
        default: write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'($urandom_range(8, 1)));
      endcase
    end
    if (pick[1]) begin
      case ($urandom_range(15, 0))
        0:       write_reg(CFG_FRAME_HEIGHT, '0);
        1:       write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(12, 7)));
        default: write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(6, 1)));
      endcase
    end
    total    = active_width() * active_height();
    cut      = ($urandom_range(4, 0) == 0) ? $urandom_range(total, 1) : 0;
    pause_at = ($urandom_range(5, 0) == 0) ? $urandom_range(total - 1, 0) : -1;
    send_frame(cut, pause_at);
  endtask

  initial begin : stimulus
    int goal;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_FRAME_WIDTH;
    cfg_data   <= '0;
    src_valid  <= 1'b0;
    word_type  <= WORD_PIXEL;
    word_pixel <= '0;
    clear_demosaic_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry (640 wide): enough pixels to get results out of the first row
    repeat (660) send_word(WORD_PIXEL, pick_sample());
    pos_lost = 1'b1;

    foreach (PLAN[i]) run_row(PLAN[i]);

    // back-pressure: sink freezes for a long stretch while the source streams
    // without gaps, so the pipe backs up into in_stall; later the source itself
    // waits mid-frame for everything to come back
    write_reg(CFG_FRAME_WIDTH, 16'd12);
    write_reg(CFG_FRAME_HEIGHT, 16'd8);
    src_mode  = 0;
    sink_mode = 1;
    sink_hold = 300;
    send_frame(0, 50);

    goal = fed_words + 1200;
    while (fed_words < goal) random_phase();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("bayer_bilinear_demosaic_luma regression: pass");
    end else begin
      $display("bayer_bilinear_demosaic_luma regression: fail");
    end
    $finish;
  end

  // Result side: random stall per word, or the one long hold when asked.
  initial begin : sink
    int gap;
    res_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (sink_hold > 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end else begin
        gap = idle_draw(sink_mode);
      end
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  // ---------------------------------------------------------------- checks
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    pix_rgb_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result word with none pending, red %0d", res_red));
      end else begin
        want = pending_pixels.pop_front();
        if (res_red !== want.red)
          report_mismatch($sformatf("red %0d, want %0d", res_red, want.red));
        if (res_green !== want.green)
          report_mismatch($sformatf("green %0d, want %0d", res_green, want.green));
        if (res_blue !== want.blue)
          report_mismatch($sformatf("blue %0d, want %0d", res_blue, want.blue));
        if (res_luma !== want.luma)
          report_mismatch($sformatf("luma %0d, want %0d", res_luma, want.luma));
        if (res_frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %0b, want %0b", res_frame_end, want.frame_end));
      end
    end
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #25_000_000;
    $display("bayer_bilinear_demosaic_luma regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bbd_pkg.sv
rtl/core/bbd_line_store.sv
rtl/core/bbd_kernel.sv
rtl/core/bbd_luma.sv
rtl/core/bayer_bilinear_demosaic_luma.sv
bench/bayer_bilinear_demosaic_luma_test.sv
